### hw/rtl/rxp_pkg.sv
// ----------------------------------------------------------------------------
// rxp_pkg
// Shared token codes, status codes and controller/datapath types for the
// regex infix-to-postfix converter.
// ----------------------------------------------------------------------------
package rxp_pkg;

	// output token codes
	localparam logic [7:0] TOK_CONCAT = 8'h1F;
	localparam logic [7:0] TOK_ANY    = 8'h80;
	localparam logic [7:0] TOK_BOL    = 8'h81;
	localparam logic [7:0] TOK_EOL    = 8'h82;
	localparam logic [7:0] TOK_ALT    = 8'h7C;
	localparam logic [7:0] TOK_TERM   = 8'h00;

	// pattern characters
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ALT    = 8'h7C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_LONG    = 3'd1;
	localparam logic [2:0] ST_NEST    = 3'd2;
	localparam logic [2:0] ST_OPERAND = 3'd3;
	localparam logic [2:0] ST_CLOSE   = 3'd4;
	localparam logic [2:0] ST_OPEN    = 3'd5;
	localparam logic [2:0] ST_ALT     = 3'd6;

	// input actions
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam logic [15:0] LIMIT_RESET = 16'd4000;

	typedef enum logic [1:0] {
		EM_CAT,
		EM_TOK,
		EM_ALT,
		EM_TERM
	} emit_sel_t;

	typedef struct packed {
		logic cat;
		logic tok;
		logic alts;
		logic pop;
		logic term;
	} plan_t;

	typedef struct packed {
		logic      accept;
		logic      emit;
		emit_sel_t sel;
		logic      pop;
	} rxp_cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  out_free;
		logic  alt_one;
	} rxp_stat_t;

endpackage

### hw/rtl/rxp_if.sv
// ----------------------------------------------------------------------------
// rxp interfaces
// Valid/ready channels for pattern beats, postfix beats and the limit write.
// ----------------------------------------------------------------------------
interface rxp_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink   (input valid, input action, input symbol, output ready);
endinterface

interface rxp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] token;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output token, output status, output last, input ready);
	modport sink   (input valid, input token, input status, input last, output ready);
endinterface

interface rxp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rxp_ctrl.sv
// ----------------------------------------------------------------------------
// rxp_ctrl
// Sequencer: takes a decoded plan per pattern beat and walks its steps
// (concat, token, alternation flush, pop, terminator).
// ----------------------------------------------------------------------------
module rxp_ctrl
	import rxp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rxp_stat_t stat,
	output rxp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CAT,
		S_TOK,
		S_ALT,
		S_POP,
		S_TERM
	} state_t;

	state_t state_q;
	plan_t  plan_q;
	plan_t  rest;
	logic   done;

	function automatic state_t first_step(input plan_t p);
		state_t s;
		if (p.cat) begin
			s = S_CAT;
		end else if (p.tok) begin
			s = S_TOK;
		end else if (p.alts) begin
			s = S_ALT;
		end else if (p.pop) begin
			s = S_POP;
		end else if (p.term) begin
			s = S_TERM;
		end else begin
			s = S_IDLE;
		end
		return s;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid && (state_q == S_IDLE);
		cmd.sel    = EM_CAT;
		rest       = plan_q;
		done       = 1'b0;
		case (state_q)
			S_CAT: begin
				cmd.emit = stat.out_free;
				cmd.sel  = EM_CAT;
				done     = stat.out_free;
				rest.cat = 1'b0;
			end
			S_TOK: begin
				cmd.emit = stat.out_free;
				cmd.sel  = EM_TOK;
				done     = stat.out_free;
				rest.tok = 1'b0;
			end
			S_ALT: begin
				cmd.emit  = stat.out_free;
				cmd.sel   = EM_ALT;
				done      = stat.out_free && stat.alt_one;
				rest.alts = 1'b0;
			end
			S_POP: begin
				cmd.pop  = 1'b1;
				done     = 1'b1;
				rest.pop = 1'b0;
			end
			S_TERM: begin
				cmd.emit  = stat.out_free;
				cmd.sel   = EM_TERM;
				done      = stat.out_free;
				rest.term = 1'b0;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plan_q  <= '0;
		end else if (cmd.accept) begin
			plan_q  <= stat.plan;
			state_q <= first_step(stat.plan);
		end else if (done) begin
			plan_q  <= rest;
			state_q <= first_step(rest);
		end
	end

endmodule

### hw/rtl/rxp_dp.sv
// ----------------------------------------------------------------------------
// rxp_dp
// Datapath: beat decode, pattern state, nesting stack memory, limit register
// and the output register.
// ----------------------------------------------------------------------------
module rxp_dp
	import rxp_pkg::*;
#(
	parameter int NEST_MAX = 128,
	parameter int ALT_MAX  = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rxp_cmd_t    cmd,
	output rxp_stat_t   stat,
	input  logic        action,
	input  logic [7:0]  symbol,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  token,
	output logic [2:0]  status,
	output logic        last
);

	localparam int DW = $clog2(NEST_MAX + 1);
	localparam int AW = (NEST_MAX > 1) ? $clog2(NEST_MAX) : 1;

	logic [15:0]   limit_q;
	logic [1:0]    atom_q;
	logic [4:0]    alt_q;
	logic [DW-1:0] depth_q;
	logic          esc_q;
	logic [15:0]   bc_q;
	logic [2:0]    err_q;
	logic [7:0]    tok_q;
	logic [6:0]    rd_q;
	logic [6:0]    stack_mem [NEST_MAX];

	logic          out_valid_q;
	logic [7:0]    token_q;
	logic [2:0]    status_q;
	logic          last_q;

	logic [1:0]    n_atom;
	logic [4:0]    n_alt;
	logic [DW-1:0] n_depth;
	logic          n_esc;
	logic [15:0]   n_bc;
	logic [15:0]   bc_inc;
	logic [2:0]    n_err;
	logic [7:0]    n_tok;
	plan_t         plan;
	logic          push;
	logic          is_atom;
	logic [7:0]    atom_tok;
	logic [6:0]    push_data;
	logic [DW-1:0] depth_dec;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign depth_dec = depth_q - DW'(1);
	assign rd_addr   = depth_dec[AW-1:0];
	assign wr_addr   = depth_q[AW-1:0];
	assign bc_inc    = (bc_q == 16'hFFFF) ? bc_q : bc_q + 16'd1;
	assign push_data = {alt_q, (atom_q == 2'd2) ? 2'd1 : atom_q};

	always_comb begin
		n_atom   = atom_q;
		n_alt    = alt_q;
		n_depth  = depth_q;
		n_esc    = esc_q;
		n_bc     = bc_q;
		n_err    = err_q;
		n_tok    = tok_q;
		plan     = '0;
		push     = 1'b0;
		is_atom  = 1'b0;
		atom_tok = symbol;
		if (action == ACT_END) begin
			if (bc_q >= limit_q) begin
				n_err = ST_LONG;
			end else if (err_q == ST_OK && depth_q != '0) begin
				n_err = ST_OPEN;
			end
			if (n_err == ST_OK) begin
				plan.cat  = (atom_q == 2'd2);
				plan.alts = (alt_q != 5'd0);
			end
			plan.term = 1'b1;
			n_atom    = 2'd0;
		end else begin
			n_bc = bc_inc;
			if (bc_inc >= limit_q) begin
				n_err = ST_LONG;
			end else if (err_q == ST_OK) begin
				if (esc_q) begin
					n_esc   = 1'b0;
					is_atom = 1'b1;
				end else begin
					case (symbol)
						CH_LPAREN: begin
							if (depth_q >= DW'(NEST_MAX)) begin
								n_err = ST_NEST;
							end else begin
								plan.cat = (atom_q == 2'd2);
								push     = 1'b1;
								n_depth  = depth_q + DW'(1);
								n_alt    = 5'd0;
								n_atom   = 2'd0;
							end
						end
						CH_ALT: begin
							if (atom_q == 2'd0) begin
								n_err = ST_OPERAND;
							end else if (alt_q >= 5'(ALT_MAX)) begin
								n_err = ST_ALT;
							end else begin
								plan.cat = (atom_q == 2'd2);
								n_atom   = 2'd0;
								n_alt    = alt_q + 5'd1;
							end
						end
						CH_RPAREN: begin
							if (depth_q == '0) begin
								n_err = ST_CLOSE;
							end else if (atom_q == 2'd0) begin
								n_err = ST_OPERAND;
							end else begin
								plan.cat  = (atom_q == 2'd2);
								plan.alts = (alt_q != 5'd0);
								plan.pop  = 1'b1;
								n_atom    = 2'd0;
							end
						end
						CH_CARET: begin
							is_atom  = 1'b1;
							atom_tok = TOK_BOL;
						end
						CH_DOLLAR: begin
							is_atom  = 1'b1;
							atom_tok = TOK_EOL;
						end
						CH_DOT: begin
							is_atom  = 1'b1;
							atom_tok = TOK_ANY;
						end
						CH_STAR, CH_PLUS, CH_QUEST: begin
							if (atom_q == 2'd0) begin
								n_err = ST_OPERAND;
							end else begin
								plan.tok = 1'b1;
								n_tok    = symbol;
							end
						end
						CH_BSLASH: begin
							n_esc = 1'b1;
						end
						default: begin
							is_atom = 1'b1;
						end
					endcase
				end
				if (is_atom) begin
					plan.cat = (atom_q == 2'd2);
					plan.tok = 1'b1;
					n_tok    = atom_tok;
					n_atom   = (atom_q >= 2'd2) ? 2'd2 : atom_q + 2'd1;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			atom_q      <= 2'd0;
			alt_q       <= 5'd0;
			depth_q     <= '0;
			esc_q       <= 1'b0;
			bc_q        <= 16'd0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.accept) begin
				atom_q  <= n_atom;
				alt_q   <= n_alt;
				depth_q <= n_depth;
				esc_q   <= n_esc;
				bc_q    <= n_bc;
				err_q   <= n_err;
			end
			if (cmd.emit && cmd.sel == EM_ALT) begin
				alt_q <= alt_q - 5'd1;
			end
			if (cmd.pop) begin
				depth_q <= depth_dec;
				alt_q   <= rd_q[6:2];
				atom_q  <= rd_q[1:0] + 2'd1;
			end
			if (cmd.emit && cmd.sel == EM_TERM) begin
				atom_q  <= 2'd0;
				alt_q   <= 5'd0;
				depth_q <= '0;
				esc_q   <= 1'b0;
				bc_q    <= 16'd0;
				err_q   <= ST_OK;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and stack memory
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tok_q <= n_tok;
		end
		if (cmd.accept && push) begin
			stack_mem[wr_addr] <= push_data;
		end
		rd_q <= stack_mem[rd_addr];
		if (cmd.emit) begin
			case (cmd.sel)
				EM_CAT: begin
					token_q  <= TOK_CONCAT;
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
				EM_TOK: begin
					token_q  <= tok_q;
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
				EM_ALT: begin
					token_q  <= TOK_ALT;
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
				EM_TERM: begin
					token_q  <= TOK_TERM;
					status_q <= err_q;
					last_q   <= 1'b1;
				end
				default: begin
					token_q  <= TOK_TERM;
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
			endcase
		end
	end

	assign stat.plan     = plan;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.alt_one  = (alt_q == 5'd1);

	assign out_valid = out_valid_q;
	assign token     = token_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

### hw/rtl/regex_infix_to_postfix.sv
// ----------------------------------------------------------------------------
// regex_infix_to_postfix
// Streaming regex infix-to-postfix converter: pattern beats in, postfix
// token beats out, with error status on the terminator beat.
//
//   channel  | dir | fields                  | note
//   ---------+-----+-------------------------+------------------------------
//   pattern  | in  | action, symbol          | one pattern byte or end mark
//   postfix  | out | token, status, last     | registered output
//   cfg      | in  | data                    | length limit, always ready
//
// A pattern beat is accepted and then emits its tokens (0 to 2); ')' also
// pops the stack, and ')' or the end beat emit one alternation token per
// pending alternation.
// The stack pop waits on the registered read of the nesting stack memory.
// Reset clears all pattern state and sets the limit to 4000.
// A stalled postfix beat holds the sequencer; pattern ready stays low until
// the current beat's tokens are all in the output register.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix
	import rxp_pkg::*;
#(
	parameter int NEST_MAX = 128,
	parameter int ALT_MAX  = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	rxp_in_if.sink    pattern,
	rxp_out_if.source postfix,
	rxp_cfg_if.sink   cfg
);

	rxp_cmd_t  cmd;
	rxp_stat_t stat;

	assign cfg.ready = 1'b1;

	rxp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pattern.valid),
		.in_ready (pattern.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rxp_dp #(
		.NEST_MAX (NEST_MAX),
		.ALT_MAX  (ALT_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.action    (pattern.action),
		.symbol    (pattern.symbol),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (postfix.ready),
		.out_valid (postfix.valid),
		.token     (postfix.token),
		.status    (postfix.status),
		.last      (postfix.last)
	);

endmodule

### hw/rtl/rxp_checker.sv
// ----------------------------------------------------------------------------
// rxp_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rxp_checker
	import rxp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] token,
	input logic [2:0] status,
	input logic       last
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token) && $stable(status)
			&& $stable(last))
		else $error("postfix beat changed while stalled");

	// error status only on the final beat
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last)
		else $error("error status on a non-final beat");

	// terminator carries token zero
	a_term_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> token == TOK_TERM)
		else $error("terminator beat with nonzero token");

endmodule

bind regex_infix_to_postfix rxp_checker u_rxp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (postfix.valid),
	.out_ready (postfix.ready),
	.token     (postfix.token),
	.status    (postfix.status),
	.last      (postfix.last)
);

### dv/regex_infix_to_postfix_test.sv
// ----------------------------------------------------------------------------
// regex_infix_to_postfix_test
// Self-checking bench for the regex infix-to-postfix converter. Patterns go
// in as bursty valid/ready beats, from hand-picked corner cases to random
// well-formed regexes, noise, deep nesting and long alternation chains,
// under several length limits. A built-in converter predicts every postfix
// beat, including the error status on the terminator, and the postfix side
// is checked beat by beat while the sink stalls on patterns of its own.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix_test
	import rxp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NEST_MAX    = 128;
	localparam int ALT_MAX     = 31;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 500000;

	localparam logic [7:0] SPECIALS [10] = '{CH_LPAREN, CH_RPAREN, CH_ALT, CH_STAR, CH_PLUS,
		CH_QUEST, CH_CARET, CH_DOLLAR, CH_DOT, CH_BSLASH};

	class postfix_checker;
		typedef struct packed {
			logic [7:0] token;
			logic [2:0] status;
			logic       last;
		} beat_t;

		beat_t       pending_tokens[$];
		logic [15:0] limit;
		logic [1:0]  atoms;
		logic [4:0]  alts;
		logic [6:0]  nest_stack [NEST_MAX];
		logic [7:0]  depth;
		bit          esc;
		logic [15:0] count;
		logic [2:0]  err;
		int          errors;

		function new();
			limit = LIMIT_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			atoms = '0;
			alts = '0;
			depth = '0;
			esc = 1'b0;
			count = '0;
			err = ST_OK;
		endfunction

		function void queue_token(logic [7:0] tok, logic [2:0] st = ST_OK, logic last = 1'b0);
			pending_tokens.push_back(beat_t'{tok, st, last});
		endfunction

		function void reduce_atoms();
			while (atoms > 1) begin
				atoms--;
				queue_token(TOK_CONCAT);
			end
			atoms = '0;
		endfunction

		function void flush_alts();
			while (alts > 0) begin
				alts--;
				queue_token(TOK_ALT);
			end
		endfunction

		function void add_atom(logic [7:0] tok);
			if (atoms > 1) begin
				atoms--;
				queue_token(TOK_CONCAT);
			end
			queue_token(tok);
			atoms++;
		endfunction

		// returns 1 for an end beat, and for a byte beat unless it falls into a pattern that already failed
		function bit convert_beat(logic act, logic [7:0] sym);
			bit live;
			live = (err == ST_OK);
			if (act == ACT_END) begin
				if (count >= limit)
					err = ST_LONG;
				if (err == ST_OK && depth != 0)
					err = ST_OPEN;
				if (err == ST_OK) begin
					reduce_atoms();
					flush_alts();
				end
				queue_token(TOK_TERM, err, 1'b1);
				clear();
				return 1'b1;
			end
			if (count != 16'hFFFF)
				count++;
			if (count >= limit)
				err = ST_LONG;
			if (err != ST_OK)
				return live;
			if (esc) begin
				esc = 1'b0;
				add_atom(sym);
				return live;
			end
			case (sym)
				CH_LPAREN: begin
					if (depth >= NEST_MAX) begin
						err = ST_NEST;
					end else begin
						if (atoms > 1) begin
							atoms--;
							queue_token(TOK_CONCAT);
						end
						nest_stack[depth[6:0]] = {alts, atoms};
						depth++;
						alts = '0;
						atoms = '0;
					end
				end
				CH_ALT: begin
					if (atoms == 0)
						err = ST_OPERAND;
					else if (alts >= ALT_MAX)
						err = ST_ALT;
					else begin
						reduce_atoms();
						alts++;
					end
				end
				CH_RPAREN: begin
					if (depth == 0 || depth > NEST_MAX)
						err = ST_CLOSE;
					else if (atoms == 0)
						err = ST_OPERAND;
					else begin
						reduce_atoms();
						flush_alts();
						depth--;
						alts = nest_stack[depth[6:0]][6:2];
						atoms = nest_stack[depth[6:0]][1:0] + 2'd1;
					end
				end
				CH_CARET:  add_atom(TOK_BOL);
				CH_DOLLAR: add_atom(TOK_EOL);
				CH_DOT:    add_atom(TOK_ANY);
				CH_STAR, CH_PLUS, CH_QUEST: begin
					if (atoms == 0)
						err = ST_OPERAND;
					else
						queue_token(sym);
				end
				CH_BSLASH: esc = 1'b1;
				default:   add_atom(sym);
			endcase
			return live;
		endfunction

		function void check_token(logic [7:0] token, logic [2:0] status, logic last);
			beat_t want;
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected postfix beat token %h status %0d last %b",
					$time, token, status, last);
				return;
			end
			want = pending_tokens.pop_front();
			if (token !== want.token) begin
				errors++;
				$display("%0t: token expected %h got %h", $time, want.token, token);
			end
			if (status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d got %0d", $time, want.status, status);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last expected %b got %b", $time, want.last, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   burst_left;
	int   live_sent;
	int   cycles = 0;

	postfix_checker postfix_chk = new();

	rxp_in_if  pat_if();
	rxp_out_if pf_if();
	rxp_cfg_if cfg_if();

	regex_infix_to_postfix u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pattern (pat_if),
		.postfix (pf_if),
		.cfg     (cfg_if)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pf_if.valid && pf_if.ready)
			postfix_chk.check_token(pf_if.token, pf_if.status, pf_if.last);
	end

	// sink stall patterns
	initial begin
		int mode;
		int hold;
		pf_if.ready = 1'b0;
		mode = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				mode = $urandom_range(0, 3);
				hold = $urandom_range(16, 128);
			end
			hold--;
			case (mode)
				0: pf_if.ready <= 1'b1;
				1: pf_if.ready <= 1'($urandom_range(0, 1));
				2: pf_if.ready <= ($urandom_range(0, 7) == 0) ? ~pf_if.ready : pf_if.ready;
				default: pf_if.ready <= (hold % 4 == 0);
			endcase
		end
	end

	task automatic send_beat(logic act, logic [7:0] sym);
		if (burst_left == 0) begin
			pat_if.valid <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 1) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		pat_if.valid  <= 1'b1;
		pat_if.action <= act;
		pat_if.symbol <= sym;
		@(posedge clk);
		while (!pat_if.ready)
			@(posedge clk);
		if (postfix_chk.convert_beat(act, sym))
			live_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic end_pattern();
		send_beat(ACT_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_chars(string text, bit close);
		for (int i = 0; i < text.len(); i++)
			send_beat(ACT_BYTE, text[i]);
		if (close)
			end_pattern();
	endtask

	task automatic send_literal();
		logic [7:0] sym;
		sym = 8'($urandom_range(0, 255));
		if (sym inside {CH_LPAREN, CH_RPAREN, CH_ALT, CH_STAR, CH_PLUS, CH_QUEST,
				CH_CARET, CH_DOLLAR, CH_DOT, CH_BSLASH})
			send_beat(ACT_BYTE, CH_BSLASH);
		send_beat(ACT_BYTE, sym);
	endtask

	task automatic send_atom();
		case ($urandom_range(0, 5))
			0: send_beat(ACT_BYTE, CH_DOT);
			1: send_beat(ACT_BYTE, CH_CARET);
			2: send_beat(ACT_BYTE, CH_DOLLAR);
			3: begin
				send_beat(ACT_BYTE, CH_BSLASH);
				send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
			end
			default: send_literal();
		endcase
	endtask

	task automatic send_regex(int max_len);
		int         n;
		int         open;
		int         r;
		bit         operand;
		logic [7:0] q;
		n = $urandom_range(1, max_len);
		open = 0;
		operand = 1'b0;
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (operand && r == 0) begin
				case ($urandom_range(0, 2))
					0: q = CH_STAR;
					1: q = CH_PLUS;
					default: q = CH_QUEST;
				endcase
				send_beat(ACT_BYTE, q);
			end else if (operand && r == 1) begin
				send_beat(ACT_BYTE, CH_ALT);
				operand = 1'b0;
			end else if (r == 2 && open < 6) begin
				send_beat(ACT_BYTE, CH_LPAREN);
				open++;
				operand = 1'b0;
			end else if (operand && open > 0 && r == 3) begin
				send_beat(ACT_BYTE, CH_RPAREN);
				open--;
			end else begin
				send_atom();
				operand = 1'b1;
			end
		end
		if (!operand)
			send_atom();
		repeat (open)
			send_beat(ACT_BYTE, CH_RPAREN);
		end_pattern();
	endtask

	task automatic send_noise(int max_len);
		repeat ($urandom_range(1, max_len)) begin
			if ($urandom_range(0, 1))
				send_beat(ACT_BYTE, SPECIALS[4'($urandom_range(0, 9))]);
			else
				send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
		end
		end_pattern();
	endtask

	task automatic send_alternation(int count, bit wrap);
		if (wrap)
			send_beat(ACT_BYTE, CH_LPAREN);
		send_literal();
		repeat (count) begin
			send_beat(ACT_BYTE, CH_ALT);
			send_literal();
			if ($urandom_range(0, 7) == 0)
				send_literal();
		end
		if (wrap)
			send_beat(ACT_BYTE, CH_RPAREN);
		end_pattern();
	endtask

	// filler between levels only on patterns that stay within the stack
	task automatic send_nesting(int levels);
		repeat (levels) begin
			if (levels <= NEST_MAX) begin
				case ($urandom_range(0, 3))
					1: send_literal();
					2: begin
						send_literal();
						send_beat(ACT_BYTE, CH_ALT);
					end
					3: begin
						send_literal();
						send_literal();
					end
					default: ;
				endcase
			end
			send_beat(ACT_BYTE, CH_LPAREN);
		end
		send_beat(ACT_BYTE, CH_DOT);
		repeat ((levels > NEST_MAX) ? 3 : levels)
			send_beat(ACT_BYTE, CH_RPAREN);
		end_pattern();
	endtask

	task automatic drain();
		pat_if.valid <= 1'b0;
		burst_left = 0;
		while (postfix_chk.pending_tokens.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_limit(logic [15:0] value);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		postfix_chk.limit = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_random(int target);
		int start;
		start = live_sent;
		while (live_sent - start < target) begin
			if ($urandom_range(0, 19) == 0)
				send_alternation($urandom_range(1, 6), 1'($urandom_range(0, 1)));
			else if ($urandom_range(0, 9) < 7)
				send_regex(12);
			else
				send_noise(8);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		pat_if.valid  = 1'b0;
		pat_if.action = ACT_BYTE;
		pat_if.symbol = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = '0;
		burst_left    = 0;
		live_sent     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send_beat(ACT_BYTE, 8'h00);
		send_beat(ACT_END, 8'hFF);
		send_beat(ACT_END, 8'h00);
		send_chars("(^\\.|", 1'b0);
		send_beat(ACT_BYTE, 8'hFF);
		send_chars(")+?$", 1'b1);
		send_chars("a|", 1'b1);
		send_chars("\\", 1'b1);
		send_chars("*x", 1'b1);
		send_chars(")", 1'b1);
		send_chars("(", 1'b1);

		write_limit(16'hFFFF);
		send_nesting(6);
		send_nesting(NEST_MAX + 1);
		send_alternation(ALT_MAX, 1'b1);
		send_alternation(ALT_MAX + 1, 1'b0);
		run_random(10);

		write_limit(16'd6);
		run_random(6);
		write_limit(16'd1);
		run_random(2);
		write_limit(16'd0);
		run_random(2);
		write_limit(16'($urandom_range(2, 30)));
		run_random(6);
		write_limit(LIMIT_RESET);
		run_random(14);

		drain();
		if (postfix_chk.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
